FILE: src/bzcd_pkg.sv
`timescale 1ns / 1ps
// Package for the back-EMF zero-crossing detector: widths, payload structs,
// command and register codes, commutation step tables. No dependencies.
package bzcd_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 16;

  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int SUM_BITS    = SAMPLE_BITS + 2;
  localparam int STEP_BITS   = 3;
  localparam int RUN_BITS    = 4;
  localparam int CFG_IDX_BITS = 3;

  // floor(x / 3) = (x * RECIP3) >> RECIP_SHIFT for any x below 2^SUM_BITS
  localparam int RECIP_SHIFT = SUM_BITS + 2;
  localparam logic [RECIP_SHIFT-1:0] RECIP3 =
    RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);

  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(5);

  localparam logic [DIFF_BITS-1:0] DIFF_NONE_LOW  = {1'b0, {SAMPLE_BITS{1'b1}}};
  localparam logic [DIFF_BITS-1:0] DIFF_NONE_HIGH = {1'b1, {SAMPLE_BITS{1'b0}}};

  localparam logic [SAMPLE_BITS-1:0] DEADBAND_RST  = SAMPLE_BITS'(8);
  localparam logic [RUN_BITS-1:0]    CONFIRM_RST   = RUN_BITS'(3);
  localparam logic [RUN_BITS-1:0]    BLANK_RST     = RUN_BITS'(2);
  localparam logic [SAMPLE_BITS-1:0] SAT_LOW_RST   = SAMPLE_BITS'(50);
  localparam logic [SAMPLE_BITS-1:0] SAT_HIGH_RST  = SAMPLE_BITS'(4045);
  localparam logic                   POL_INV_RST   = 1'b1;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DEADBAND = 3'd0,
    REG_CONFIRM  = 3'd1,
    REG_BLANK    = 3'd2,
    REG_SAT_LOW  = 3'd3,
    REG_SAT_HIGH = 3'd4,
    REG_POL_INV  = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_C = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic [SAMPLE_BITS-1:0] sample_c;
    logic [STEP_BITS-1:0]   step_value;
    logic                   sense_enable;
  } in_item_t;

  typedef struct packed {
    logic [STEP_BITS-1:0]   current_step;
    logic                   zc_detected;
    logic                   zc_wrong_seen;
    logic                   zc_locked;
    logic [DIFF_BITS-1:0]   floating_diff;
    logic [SAMPLE_BITS-1:0] neutral_level;
    logic [COUNT_BITS-1:0]  correct_total;
    logic [COUNT_BITS-1:0]  wrong_total;
    logic [COUNT_BITS-1:0]  sat_low_total;
    logic [COUNT_BITS-1:0]  sat_high_total;
    logic [DIFF_BITS-1:0]   diff_low_mark;
    logic [DIFF_BITS-1:0]   diff_high_mark;
  } out_item_t;

  // floating phase per step: C B A C B A
  function automatic phase_t float_phase(input logic [STEP_BITS-1:0] s);
    phase_t p;
    case (s)
      3'd0, 3'd3: p = PH_C;
      3'd1, 3'd4: p = PH_B;
      default:    p = PH_A;
    endcase
    return p;
  endfunction

  // even steps see a rising floating phase
  function automatic logic nominal_rising(input logic [STEP_BITS-1:0] s);
    return ~s[0];
  endfunction

endpackage

FILE: src/bemf_zero_cross_detector.sv
`timescale 1ns / 1ps
// Back-EMF zero-crossing detector for a six-step drive.
// Depends on bzcd_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one command per
//   transaction: sample (three phase ADC readings), advance step, load step
//   or clear statistics. Every transaction yields exactly one result on the
//   output channel (out_valid / out_stall / out_data) with the step in force,
//   crossing flags, the last neutral and floating difference, and the
//   saturating statistics.
//   A result passes through the input register, then the result register.
//   Throughput: one transaction per cycle while the receiver does not stall;
//   the whole per-item update fits between the two registers.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more transaction, after which in_stall follows out_stall.
//   Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are
//   always taken; indexes past the register list are dropped.
//   Synchronous reset (rst_n low) empties both registers, restores the
//   register defaults, arms step 0 and clears the statistics.
module bemf_zero_cross_detector (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bzcd_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bzcd_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bzcd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [bzcd_pkg::SAMPLE_BITS-1:0]    cfg_data
);
  import bzcd_pkg::*;

  typedef struct packed {
    logic                sign_pos;
    logic [RUN_BITS-1:0] run;
    logic                fire;
  } filt_t;

  // config
  logic [SAMPLE_BITS-1:0] deadband_r, sat_low_r, sat_high_r;
  logic [RUN_BITS-1:0]    confirm_r, blank_scans_r;
  logic                   pol_inv_r;

  // pipeline
  logic     s1_valid_r;
  in_item_t s1_data_r;
  logic     out_valid_r;
  out_item_t out_data_r, out_nxt;
  logic     adv, fire;

  // detector state
  logic [STEP_BITS-1:0]   step_r, step_nxt;
  logic                   exp_pos_r, exp_pos_nxt, anti_pos_r, anti_pos_nxt;
  logic [RUN_BITS-1:0]    exp_run_r, exp_run_nxt, anti_run_r, anti_run_nxt;
  logic                   locked_r, locked_nxt;
  logic [RUN_BITS-1:0]    blank_r, blank_nxt;
  logic [COUNT_BITS-1:0]  good_r, good_nxt, bad_r, bad_nxt;
  logic [COUNT_BITS-1:0]  slow_r, slow_nxt, shigh_r, shigh_nxt;
  logic [DIFF_BITS-1:0]   min_r, min_nxt, max_r, max_nxt;
  logic [DIFF_BITS-1:0]   diff_r, diff_nxt;
  logic [SAMPLE_BITS-1:0] neut_r, neut_nxt;

  // datapath
  logic [SUM_BITS-1:0]             sum;
  logic [SUM_BITS+RECIP_SHIFT-1:0] prod;
  logic [SAMPLE_BITS-1:0]          neutral, fv;
  logic [DIFF_BITS-1:0]            d;
  logic [RUN_BITS-1:0]             need;
  filt_t                           ef, af;
  logic                            det, wrong;
  logic                            arm;
  logic [STEP_BITS-1:0]            arm_step;
  logic                            arm_rising;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic filt_t filt(input logic sign_pos, input logic [RUN_BITS-1:0] run,
                                 input logic [DIFF_BITS-1:0] dv,
                                 input logic [SAMPLE_BITS-1:0] db,
                                 input logic [RUN_BITS-1:0] nd);
    logic signed [DIFF_BITS:0] dx, dbx;
    logic q;
    filt_t f;
    dx  = $signed({dv[DIFF_BITS-1], dv});
    dbx = $signed({2'b00, db});
    q   = sign_pos ? (dx <= -dbx) : (dx >= dbx);
    f.sign_pos = sign_pos;
    f.fire     = 1'b0;
    if (q) begin
      f.run = (run < nd) ? run + RUN_BITS'(1) : run;
    end else begin
      f.run = '0;
    end
    if (f.run >= nd) begin
      f.run      = '0;
      f.sign_pos = ~sign_pos;
      f.fire     = 1'b1;
    end
    return f;
  endfunction

  assign adv       = ~out_valid_r | ~out_stall;
  assign fire      = s1_valid_r & adv;
  assign in_stall  = s1_valid_r & ~adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // neutral = sum / 3 by reciprocal multiply
  assign sum     = SUM_BITS'(s1_data_r.sample_a) + SUM_BITS'(s1_data_r.sample_b)
                 + SUM_BITS'(s1_data_r.sample_c);
  assign prod    = (SUM_BITS+RECIP_SHIFT)'(sum) * (SUM_BITS+RECIP_SHIFT)'(RECIP3);
  assign neutral = prod[RECIP_SHIFT +: SAMPLE_BITS];
  assign need    = (confirm_r == '0) ? RUN_BITS'(1) : confirm_r;

  always_comb begin
    case (float_phase(step_r))
      PH_A:    fv = s1_data_r.sample_a;
      PH_B:    fv = s1_data_r.sample_b;
      default: fv = s1_data_r.sample_c;
    endcase
  end

  assign d  = {1'b0, fv} - {1'b0, neutral};
  assign ef = filt(exp_pos_r, exp_run_r, d, deadband_r, need);
  assign af = filt(anti_pos_r, anti_run_r, d, deadband_r, need);

  always_comb begin
    step_nxt     = step_r;
    exp_pos_nxt  = exp_pos_r;
    anti_pos_nxt = anti_pos_r;
    exp_run_nxt  = exp_run_r;
    anti_run_nxt = anti_run_r;
    locked_nxt   = locked_r;
    blank_nxt    = blank_r;
    good_nxt     = good_r;
    bad_nxt      = bad_r;
    slow_nxt     = slow_r;
    shigh_nxt    = shigh_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    diff_nxt     = diff_r;
    neut_nxt     = neut_r;
    det          = 1'b0;
    wrong        = 1'b0;
    arm          = 1'b0;
    arm_step     = '0;

    case (cmd_t'(s1_data_r.cmd))
      CMD_SAMPLE: begin
        neut_nxt = neutral;
        if (s1_data_r.sense_enable) begin
          diff_nxt = d;
          if (blank_r != '0) begin
            blank_nxt = blank_r - RUN_BITS'(1);
          end else begin
            if (fv <= sat_low_r)  slow_nxt  = sat_inc(slow_r);
            if (fv >= sat_high_r) shigh_nxt = sat_inc(shigh_r);
            if ($signed(d) < $signed(min_r)) min_nxt = d;
            if ($signed(d) > $signed(max_r)) max_nxt = d;
            if (!locked_r) begin
              exp_pos_nxt = ef.sign_pos;
              exp_run_nxt = ef.run;
              if (ef.fire) begin
                locked_nxt = 1'b1;
                det        = 1'b1;
                good_nxt   = sat_inc(good_r);
              end
            end
            anti_pos_nxt = af.sign_pos;
            anti_run_nxt = af.run;
            if (af.fire) begin
              wrong   = 1'b1;
              bad_nxt = sat_inc(bad_r);
            end
          end
        end
      end
      CMD_ADVANCE: begin
        arm      = 1'b1;
        arm_step = (step_r >= LAST_STEP) ? '0 : step_r + STEP_BITS'(1);
      end
      CMD_LOAD: begin
        arm      = (s1_data_r.step_value <= LAST_STEP);
        arm_step = s1_data_r.step_value;
      end
      CMD_CLEAR: begin
        good_nxt  = '0;
        bad_nxt   = '0;
        slow_nxt  = '0;
        shigh_nxt = '0;
        min_nxt   = DIFF_NONE_LOW;
        max_nxt   = DIFF_NONE_HIGH;
      end
      default: ;
    endcase

    arm_rising = nominal_rising(arm_step) ^ pol_inv_r;
    if (arm) begin
      step_nxt     = arm_step;
      exp_pos_nxt  = ~arm_rising;
      anti_pos_nxt = arm_rising;
      exp_run_nxt  = '0;
      anti_run_nxt = '0;
      locked_nxt   = 1'b0;
      blank_nxt    = blank_scans_r;
    end

    out_nxt.current_step   = step_nxt;
    out_nxt.zc_detected    = det;
    out_nxt.zc_wrong_seen  = wrong;
    out_nxt.zc_locked      = locked_nxt;
    out_nxt.floating_diff  = diff_nxt;
    out_nxt.neutral_level  = neut_nxt;
    out_nxt.correct_total  = good_nxt;
    out_nxt.wrong_total    = bad_nxt;
    out_nxt.sat_low_total  = slow_nxt;
    out_nxt.sat_high_total = shigh_nxt;
    out_nxt.diff_low_mark  = min_nxt;
    out_nxt.diff_high_mark = max_nxt;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r    <= DEADBAND_RST;
      confirm_r     <= CONFIRM_RST;
      blank_scans_r <= BLANK_RST;
      sat_low_r     <= SAT_LOW_RST;
      sat_high_r    <= SAT_HIGH_RST;
      pol_inv_r     <= POL_INV_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_DEADBAND: deadband_r    <= cfg_data;
        REG_CONFIRM:  confirm_r     <= cfg_data[RUN_BITS-1:0];
        REG_BLANK:    blank_scans_r <= cfg_data[RUN_BITS-1:0];
        REG_SAT_LOW:  sat_low_r     <= cfg_data;
        REG_SAT_HIGH: sat_high_r    <= cfg_data;
        REG_POL_INV:  pol_inv_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_nxt;
    end
  end

  // detector state; step 0 armed under reset polarity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= '0;
      exp_pos_r  <= ~(nominal_rising(STEP_BITS'(0)) ^ POL_INV_RST);
      anti_pos_r <= nominal_rising(STEP_BITS'(0)) ^ POL_INV_RST;
      exp_run_r  <= '0;
      anti_run_r <= '0;
      locked_r   <= 1'b0;
      blank_r    <= BLANK_RST;
      good_r     <= '0;
      bad_r      <= '0;
      slow_r     <= '0;
      shigh_r    <= '0;
      min_r      <= DIFF_NONE_LOW;
      max_r      <= DIFF_NONE_HIGH;
      diff_r     <= '0;
      neut_r     <= '0;
    end else if (fire) begin
      step_r     <= step_nxt;
      exp_pos_r  <= exp_pos_nxt;
      anti_pos_r <= anti_pos_nxt;
      exp_run_r  <= exp_run_nxt;
      anti_run_r <= anti_run_nxt;
      locked_r   <= locked_nxt;
      blank_r    <= blank_nxt;
      good_r     <= good_nxt;
      bad_r      <= bad_nxt;
      slow_r     <= slow_nxt;
      shigh_r    <= shigh_nxt;
      min_r      <= min_nxt;
      max_r      <= max_nxt;
      diff_r     <= diff_nxt;
      neut_r     <= neut_nxt;
    end
  end

endmodule

FILE: src/bzcd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for bemf_zero_cross_detector, bound to the top level.
// Depends on bzcd_pkg.
module bzcd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input bzcd_pkg::out_item_t out_data
);
  import bzcd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a detected crossing always leaves the step locked
  a_det_locks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zc_detected |-> out_data.zc_locked)
    else $error("crossing detected without lock");

  a_det_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zc_detected |-> out_data.correct_total != '0)
    else $error("crossing detected but correct_total is zero");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.current_step <= LAST_STEP)
    else $error("commutation step out of range");

  // the input side can only stall while a result is pending
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no pending result");

endmodule

bind bemf_zero_cross_detector bzcd_checker u_bzcd_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 1ps
// Testbench for bemf_zero_cross_detector: sends commands and register writes,
// predicts each result with its own model of the detector and checks every
// field. Depends on bzcd_pkg and the detector RTL.
module tb;
  import bzcd_pkg::*;

  localparam int CYCLE_LIMIT  = 60000;
  localparam int PRINT_LIMIT  = 40;
  localparam int CLIMB_ROUNDS = 16;
  localparam int FILT_EXPECT  = 0;
  localparam int FILT_ANTI    = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [SAMPLE_BITS-1:0]  SAMPLE_MAX   = '1;
  localparam logic [COUNT_BITS-1:0]   COUNT_MAX    = '1;
  // steps 0, 2 and 4 see a rising floating phase
  localparam logic [5:0] NOMINAL_RISING = 6'b010101;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [SAMPLE_BITS-1:0] cfg_data;

  bemf_zero_cross_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // detector model: register copies
  logic [SAMPLE_BITS-1:0] deadband_cfg;
  logic [RUN_BITS-1:0]    confirm_cfg;
  logic [RUN_BITS-1:0]    blank_cfg;
  logic [SAMPLE_BITS-1:0] sat_low_cfg;
  logic [SAMPLE_BITS-1:0] sat_high_cfg;
  logic                   pol_inv_cfg;

  // detector model: state
  logic [STEP_BITS-1:0]   cur_step;
  logic                   sign_pos [2];
  logic [RUN_BITS-1:0]    filt_run [2];
  logic                   step_locked;
  logic [RUN_BITS-1:0]    blank_left;
  logic [COUNT_BITS-1:0]  good_total;
  logic [COUNT_BITS-1:0]  bad_total;
  logic [COUNT_BITS-1:0]  low_sat_total;
  logic [COUNT_BITS-1:0]  high_sat_total;
  int                     lowest_diff;
  int                     highest_diff;
  int                     held_diff;
  logic [SAMPLE_BITS-1:0] held_neutral;

  out_item_t expected_results[$];

  int mismatch_count = 0;
  int result_count = 0;
  int accepted_count = 0;
  int reg_write_count = 0;
  int crossings_seen = 0;
  int wrong_seen = 0;
  int sent_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic [STEP_BITS-1:0] stim_step = '0;

  // ---------------------------------------------------------------- model

  function automatic void arm_step(logic [STEP_BITS-1:0] s);
    logic rising;
    rising = NOMINAL_RISING[s] ^ pol_inv_cfg;
    cur_step = s;
    sign_pos[FILT_EXPECT] = ~rising;
    sign_pos[FILT_ANTI] = rising;
    filt_run[FILT_EXPECT] = '0;
    filt_run[FILT_ANTI] = '0;
    step_locked = 1'b0;
    blank_left = blank_cfg;
  endfunction

  function automatic void clear_stats();
    good_total = '0;
    bad_total = '0;
    low_sat_total = '0;
    high_sat_total = '0;
    lowest_diff = int'(SAMPLE_MAX);
    highest_diff = -int'(SAMPLE_MAX) - 1;
  endfunction

  function automatic void reset_model();
    deadband_cfg = DEADBAND_RST;
    confirm_cfg = CONFIRM_RST;
    blank_cfg = BLANK_RST;
    sat_low_cfg = SAT_LOW_RST;
    sat_high_cfg = SAT_HIGH_RST;
    pol_inv_cfg = POL_INV_RST;
    arm_step('0);
    clear_stats();
    held_diff = 0;
    held_neutral = '0;
    expected_results.delete();
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx,
                                    logic [SAMPLE_BITS-1:0] val);
    case (idx)
      REG_DEADBAND: deadband_cfg = val;
      REG_CONFIRM:  confirm_cfg = val[RUN_BITS-1:0];
      REG_BLANK:    blank_cfg = val[RUN_BITS-1:0];
      REG_SAT_LOW:  sat_low_cfg = val;
      REG_SAT_HIGH: sat_high_cfg = val;
      REG_POL_INV:  pol_inv_cfg = val[0];
      default: ;
    endcase
  endfunction

  function automatic logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
  endfunction

  // deadband + confirm-count hysteresis; 1 when a sign change is confirmed
  function automatic logic filter_fires(int f, int d);
    logic [RUN_BITS-1:0] need;
    logic qual;
    need = (confirm_cfg == '0) ? RUN_BITS'(1) : confirm_cfg;
    qual = sign_pos[f] ? (d <= -int'(deadband_cfg)) : (d >= int'(deadband_cfg));
    if (!qual) filt_run[f] = '0;
    else if (filt_run[f] < need) filt_run[f] = filt_run[f] + RUN_BITS'(1);
    if (filt_run[f] >= need) begin
      filt_run[f] = '0;
      sign_pos[f] = ~sign_pos[f];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] floating_of(in_item_t it,
                                                         logic [STEP_BITS-1:0] s);
    case (s)
      3'd0, 3'd3: return it.sample_c;
      3'd1, 3'd4: return it.sample_b;
      default:    return it.sample_a;
    endcase
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    logic det;
    logic wrong;
    logic [SAMPLE_BITS-1:0] v;
    int d;
    det = 1'b0;
    wrong = 1'b0;
    case (cmd_t'(it.cmd))
      CMD_SAMPLE: begin
        held_neutral = SAMPLE_BITS'((int'(it.sample_a) + int'(it.sample_b)
                                     + int'(it.sample_c)) / 3);
        if (it.sense_enable) begin
          v = floating_of(it, cur_step);
          d = int'(v) - int'(held_neutral);
          held_diff = d;
          if (blank_left != '0) begin
            blank_left = blank_left - RUN_BITS'(1);
          end else begin
            if (v <= sat_low_cfg) low_sat_total = bump(low_sat_total);
            if (v >= sat_high_cfg) high_sat_total = bump(high_sat_total);
            if (d < lowest_diff) lowest_diff = d;
            if (d > highest_diff) highest_diff = d;
            if (!step_locked) begin
              if (filter_fires(FILT_EXPECT, d)) begin
                step_locked = 1'b1;
                det = 1'b1;
                good_total = bump(good_total);
              end
            end
            if (filter_fires(FILT_ANTI, d)) begin
              wrong = 1'b1;
              bad_total = bump(bad_total);
            end
          end
        end
      end
      CMD_ADVANCE: arm_step((cur_step == LAST_STEP) ? STEP_BITS'(0)
                                                    : cur_step + STEP_BITS'(1));
      CMD_LOAD: if (it.step_value <= LAST_STEP) arm_step(it.step_value);
      CMD_CLEAR: clear_stats();
      default: ;
    endcase
    r.current_step = cur_step;
    r.zc_detected = det;
    r.zc_wrong_seen = wrong;
    r.zc_locked = step_locked;
    r.floating_diff = DIFF_BITS'(held_diff);
    r.neutral_level = held_neutral;
    r.correct_total = good_total;
    r.wrong_total = bad_total;
    r.sat_low_total = low_sat_total;
    r.sat_high_total = high_sat_total;
    r.diff_low_mark = DIFF_BITS'(lowest_diff);
    r.diff_high_mark = DIFF_BITS'(highest_diff);
    return r;
  endfunction

  // ------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("ERROR at result %0d (t=%0t): %s", result_count, $realtime, msg);
  endtask

  task automatic check_field(string name, logic [COUNT_BITS-1:0] got,
                             logic [COUNT_BITS-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t want;
    result_count++;
    if (expected_results.size() == 0) begin
      report_mismatch("result with no transaction outstanding");
      return;
    end
    want = expected_results.pop_front();
    if (want.zc_detected) crossings_seen++;
    if (want.zc_wrong_seen) wrong_seen++;
    check_field("current_step", COUNT_BITS'(got.current_step),
                COUNT_BITS'(want.current_step));
    check_field("zc_detected", COUNT_BITS'(got.zc_detected),
                COUNT_BITS'(want.zc_detected));
    check_field("zc_wrong_seen", COUNT_BITS'(got.zc_wrong_seen),
                COUNT_BITS'(want.zc_wrong_seen));
    check_field("zc_locked", COUNT_BITS'(got.zc_locked), COUNT_BITS'(want.zc_locked));
    check_field("floating_diff", COUNT_BITS'(got.floating_diff),
                COUNT_BITS'(want.floating_diff));
    check_field("neutral_level", COUNT_BITS'(got.neutral_level),
                COUNT_BITS'(want.neutral_level));
    check_field("correct_total", got.correct_total, want.correct_total);
    check_field("wrong_total", got.wrong_total, want.wrong_total);
    check_field("sat_low_total", got.sat_low_total, want.sat_low_total);
    check_field("sat_high_total", got.sat_high_total, want.sat_high_total);
    check_field("diff_low_mark", COUNT_BITS'(got.diff_low_mark),
                COUNT_BITS'(want.diff_low_mark));
    check_field("diff_high_mark", COUNT_BITS'(got.diff_high_mark),
                COUNT_BITS'(want.diff_high_mark));
  endtask

  // all sampling at the rising edge sees pre-edge values
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        reg_write_count++;
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_result(in_data));
        accepted_count++;
      end
      if (out_valid && !out_stall) compare_result(out_data);
    end
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results outstanding",
             cycle_count, expected_results.size());
    $display("Mismatches found");
    $finish;
  end

  // ------------------------------------------------------------- stimulus

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] clamp(int x);
    if (x < 0) return '0;
    if (x > int'(SAMPLE_MAX)) return SAMPLE_MAX;
    return SAMPLE_BITS'(x);
  endfunction

  function automatic in_item_t make_cmd(cmd_t c, logic [STEP_BITS-1:0] s);
    in_item_t it;
    it.cmd = c;
    it.sample_a = SAMPLE_BITS'($urandom);
    it.sample_b = SAMPLE_BITS'($urandom);
    it.sample_c = SAMPLE_BITS'($urandom);
    it.step_value = s;
    it.sense_enable = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_sample(logic [SAMPLE_BITS-1:0] a,
                                           logic [SAMPLE_BITS-1:0] b,
                                           logic [SAMPLE_BITS-1:0] c,
                                           logic sense);
    in_item_t it;
    it.cmd = CMD_SAMPLE;
    it.sample_a = a;
    it.sample_b = b;
    it.sample_c = c;
    it.step_value = STEP_BITS'($urandom);
    it.sense_enable = sense;
    return it;
  endfunction

  // floating phase sits at target above a common level, driven phases near it
  function automatic in_item_t sample_toward(int target, logic sense);
    int base;
    logic [SAMPLE_BITS-1:0] v, o1, o2;
    base = int'($urandom_range(400, 3700));
    v = clamp(base + target);
    o1 = clamp(base + jitter(15));
    o2 = clamp(base + jitter(15));
    case (stim_step)
      3'd0, 3'd3: return make_sample(o1, o2, v, sense);
      3'd1, 3'd4: return make_sample(o1, v, o2, sense);
      default:    return make_sample(v, o1, o2, sense);
    endcase
  endfunction

  task automatic set_idle(int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 48; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 48; end
      default: begin idle_pct = 19; stall_pct = 19; end
    endcase
  endtask

  // called at a rising edge; returns at the edge that accepted the transaction
  task automatic send_item(in_item_t it);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if (cmd_t'(it.cmd) == CMD_ADVANCE)
      stim_step = (stim_step == LAST_STEP) ? STEP_BITS'(0) : stim_step + STEP_BITS'(1);
    else if (cmd_t'(it.cmd) == CMD_LOAD && it.step_value <= LAST_STEP)
      stim_step = it.step_value;
    if (!(cmd_t'(it.cmd) == CMD_LOAD && it.step_value > LAST_STEP)) sent_count++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SAMPLE_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_regs(int db, int conf, int blank, int lo, int hi, int pol);
    write_reg(REG_DEADBAND, SAMPLE_BITS'(db));
    write_reg(REG_CONFIRM, SAMPLE_BITS'(conf));
    write_reg(REG_BLANK, SAMPLE_BITS'(blank));
    write_reg(REG_SAT_LOW, SAMPLE_BITS'(lo));
    write_reg(REG_SAT_HIGH, SAMPLE_BITS'(hi));
    write_reg(REG_POL_INV, SAMPLE_BITS'(pol));
  endtask

  // one commutation step: a ramp of the floating phase through the neutral,
  // then usually the next step
  task automatic run_step_episode();
    int mag, len, t, lo_mag, hi_mag;
    logic falling;
    lo_mag = int'(deadband_cfg) / 2 + 10;
    hi_mag = int'(deadband_cfg) * 3 + 80;
    if (hi_mag > 2700) hi_mag = 2700;
    mag = int'($urandom_range(lo_mag, hi_mag));
    len = int'($urandom_range(2, 14)) + int'(blank_cfg);
    falling = 1'($urandom);
    for (int k = 0; k < len; k++) begin
      t = -mag + (2 * mag * k) / (len - 1);
      if (falling) t = -t;
      send_item(sample_toward(t + jitter(10), $urandom_range(0, 19) != 0));
    end
    case ($urandom_range(0, 19))
      0, 1: send_item(make_cmd(CMD_LOAD, STEP_BITS'($urandom_range(0, 7))));
      2: ;
      default: send_item(make_cmd(CMD_ADVANCE, STEP_BITS'($urandom)));
    endcase
  endtask

  task automatic send_noise_item();
    case ($urandom_range(0, 7))
      0: send_item(make_cmd(CMD_CLEAR, STEP_BITS'($urandom)));
      1: send_item(make_cmd(CMD_LOAD, STEP_BITS'($urandom_range(0, 7))));
      2: send_item(make_cmd(CMD_ADVANCE, STEP_BITS'($urandom)));
      default: send_item(make_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                                     SAMPLE_BITS'($urandom), 1'($urandom)));
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_blanking_and_disable();
    send_item(make_sample('0, '0, '0, 1'b1));
    send_item(make_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1));
    send_item(make_sample(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                          SAMPLE_BITS'($urandom), 1'b0));
  endtask

  // step 0 under inverted polarity expects a falling phase C
  task automatic test_expected_crossing();
    repeat (4) send_item(make_sample(SAMPLE_MAX, SAMPLE_MAX, '0, 1'b1));
    repeat (3) send_item(make_sample('0, '0, SAMPLE_MAX, 1'b1));
  endtask

  task automatic test_step_commands();
    send_item(make_cmd(CMD_LOAD, 3'd7));
    send_item(make_cmd(CMD_LOAD, 3'd6));
    send_item(make_cmd(CMD_LOAD, LAST_STEP));
    send_item(make_cmd(CMD_ADVANCE, 3'd2));
    send_item(make_cmd(CMD_ADVANCE, 3'd5));
    send_item(make_cmd(CMD_CLEAR, 3'd0));
    send_item(make_sample(12'hABC, 12'h543, 12'h0F0, 1'b1));
  endtask

  // zero confirm count acts as one; writes past the register list are dropped
  task automatic test_register_extremes();
    drain_results();
    write_all_regs(0, 0, 0, int'(SAMPLE_MAX), 0, 0);
    write_reg(REG_SPARE_LO, SAMPLE_MAX);
    write_reg(REG_SPARE_HI, '0);
    send_item(make_cmd(CMD_LOAD, 3'd2));
    repeat (2) send_item(make_sample(12'h800, 12'h800, 12'h800, 1'b1));
    send_item(make_cmd(CMD_ADVANCE, 3'd0));
    send_item(sample_toward(-600, 1'b1));
    drain_results();
  endtask

  task automatic test_random_phase(int mode, int n_items);
    int start;
    logic paused;
    set_idle(mode);
    start = sent_count;
    paused = 1'b0;
    while (sent_count - start < n_items) begin
      if ($urandom_range(0, 9) == 0) send_noise_item();
      else run_step_episode();
      // hold the sender until everything outstanding has come back
      if (!paused && sent_count - start >= n_items / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_all_regs(DEADBAND_RST, CONFIRM_RST, BLANK_RST, SAT_LOW_RST,
                          SAT_HIGH_RST, POL_INV_RST);
        1: write_all_regs(0, 1, 0, 0, int'(SAMPLE_MAX), 0);
        2: write_all_regs(int'(SAMPLE_MAX), 15, 15, int'(SAMPLE_MAX), 0, 1);
        default: write_all_regs($urandom_range(0, 300), $urandom_range(0, 15),
                                $urandom_range(0, 6), $urandom_range(0, 600),
                                $urandom_range(3400, 4095), $urandom_range(0, 1));
      endcase
      test_random_phase(p % 4, 90);
    end
  endtask

  // equal phases give a zero difference: with no deadband both filters fire
  // on every sample, so every counter steps on each sample between advances
  task automatic test_counter_climb();
    logic [SAMPLE_BITS-1:0] lvl;
    drain_results();
    write_all_regs(0, 1, 0, int'(SAMPLE_MAX), 0, 1);
    set_idle(0);
    for (int k = 0; k < CLIMB_ROUNDS; k++) begin
      lvl = SAMPLE_BITS'($urandom);
      send_item(make_sample(lvl, lvl, lvl, 1'b1));
      send_item(make_cmd(CMD_ADVANCE, STEP_BITS'($urandom)));
    end
    send_item(make_cmd(CMD_CLEAR, STEP_BITS'($urandom)));
    send_item(sample_toward(300, 1'b1));
    drain_results();
  endtask

  initial begin
    int wait_cycles;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(3);
    test_blanking_and_disable();
    test_expected_crossing();
    test_step_commands();
    test_register_extremes();
    test_random_traffic();
    test_counter_climb();

    in_valid <= 1'b0;
    wait_cycles = 0;
    @(posedge clk);
    while (expected_results.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (6) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("Covered %0d transactions (%0d checked) and %0d register writes,",
             accepted_count, result_count, reg_write_count);
    $display("with %0d expected and %0d wrong-direction crossings under stalls and gaps.",
             crossings_seen, wrong_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
